// ===== design/hct_pkg.sv =====
// ----------------------------------------------------------------------------
// Handheld console timer package
// Shared types, register addresses, sizing constants and the interval table.
// ----------------------------------------------------------------------------
package hct_pkg;

    localparam int DIV_INTERVAL = 256;

    localparam int DIV_REM_W   = $clog2(DIV_INTERVAL);
    localparam int PRE_REM_W   = 10;
    localparam int INTERVAL_W  = 11;
    localparam int DIV_REM_MAX = DIV_INTERVAL - 1;
    localparam int PRE_REM_MAX = 1023;
    localparam int SUM_MAX     = ((DIV_REM_MAX > PRE_REM_MAX) ? DIV_REM_MAX : PRE_REM_MAX)
                                 + 255;
    localparam int ACC_W       = $clog2(SUM_MAX + 1);

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [15:0] ADDR_DIV = 16'hff04;
    localparam logic [15:0] ADDR_CNT = 16'hff05;
    localparam logic [15:0] ADDR_MOD = 16'hff06;
    localparam logic [15:0] ADDR_CTL = 16'hff07;

    localparam logic [7:0] CTL_SEL_MASK = 8'h03;
    localparam logic [7:0] CTL_ENABLE   = 8'h04;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1024);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PRE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [7:0]  cycle_count;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic       address_error;
    } t_out_beat;

    typedef struct packed {
        logic             ge;
        logic [ACC_W-1:0] diff;
    } t_sub_result;

    function automatic logic [INTERVAL_W-1:0] sel_interval(input logic [1:0] sel);
        logic [INTERVAL_W-1:0] r;
        unique case (sel)
            2'd0: r = INTERVAL_W'(1024);
            2'd1: r = INTERVAL_W'(16);
            2'd2: r = INTERVAL_W'(64);
            2'd3: r = INTERVAL_W'(256);
            default: r = INTERVAL_W'(1024);
        endcase
        return r;
    endfunction

endpackage

// ===== design/handheld_console_timer.sv =====
// ----------------------------------------------------------------------------
// Handheld console timer
// Divider, counter, modulo and control registers with a tick-driven prescaler.
// ----------------------------------------------------------------------------
// A bus read or write goes from acceptance to the response state. A tick goes
// through the divider state, the prescaler state when the counter is enabled,
// and the response state; divider and prescaler take (remainder + cycles) /
// DIV_INTERVAL and (remainder + cycles) / interval quotient steps. Each step
// is one pass through the single shared compare and subtract unit, and the
// input is not ready until the result beat is registered.
module handheld_console_timer
    import hct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    t_state                r_state, n_state;
    logic [7:0]            r_divider, n_divider;
    logic [DIV_REM_W-1:0]  r_div_rem, n_div_rem;
    logic [7:0]            r_counter, n_counter;
    logic [7:0]            r_modulo, n_modulo;
    logic [7:0]            r_control, n_control;
    logic [PRE_REM_W-1:0]  r_pre_rem, n_pre_rem;
    logic [INTERVAL_W-1:0] r_interval, n_interval;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [7:0]            r_cycles, n_cycles;
    t_out_beat             r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out_beat, n_out_beat;

    logic [ACC_W-1:0] w_sub_b;
    t_sub_result      w_sub;
    logic             w_accept;
    logic             w_addr_ok;
    logic             w_out_free;

    hct_sub_unit u_sub (
        .i_minuend    (r_acc),
        .i_subtrahend (w_sub_b),
        .o_result     (w_sub)
    );

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_addr_ok  = (i_in_beat.bus_address >= ADDR_DIV)
                        && (i_in_beat.bus_address <= ADDR_CTL);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_beat.func == FUNC_TICK) ? ST_DIV : ST_RESP;
                end
            end
            ST_DIV: begin
                if (!w_sub.ge) begin
                    n_state = ((r_control & CTL_ENABLE) != 8'h00) ? ST_PRE : ST_RESP;
                end
            end
            ST_PRE: begin
                if (!w_sub.ge) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        w_sub_b     = (r_state == ST_PRE) ? ACC_W'(r_interval) : ACC_W'(DIV_INTERVAL);
        n_divider   = r_divider;
        n_div_rem   = r_div_rem;
        n_counter   = r_counter;
        n_modulo    = r_modulo;
        n_control   = r_control;
        n_pre_rem   = r_pre_rem;
        n_interval  = r_interval;
        n_acc       = r_acc;
        n_cycles    = r_cycles;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_beat  = r_out_beat;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res    = '0;
                    n_cycles = i_in_beat.cycle_count;
                    n_acc    = ACC_W'(r_div_rem) + ACC_W'(i_in_beat.cycle_count);
                    if (i_in_beat.func == FUNC_READ || i_in_beat.func == FUNC_WRITE) begin
                        if (!w_addr_ok) begin
                            n_res.address_error = 1'b1;
                        end else if (i_in_beat.func == FUNC_READ) begin
                            priority if (i_in_beat.bus_address == ADDR_DIV) begin
                                n_res.read_data = r_divider;
                            end else if (i_in_beat.bus_address == ADDR_CNT) begin
                                n_res.read_data = r_counter;
                            end else if (i_in_beat.bus_address == ADDR_MOD) begin
                                n_res.read_data = r_modulo;
                            end else begin
                                n_res.read_data = r_control;
                            end
                        end else begin
                            priority if (i_in_beat.bus_address == ADDR_DIV) begin
                                n_divider = '0;
                                n_div_rem = '0;
                            end else if (i_in_beat.bus_address == ADDR_CNT) begin
                                n_counter = i_in_beat.write_data;
                            end else if (i_in_beat.bus_address == ADDR_MOD) begin
                                n_modulo = i_in_beat.write_data;
                            end else begin
                                if ((r_control & CTL_SEL_MASK)
                                    != (i_in_beat.write_data & CTL_SEL_MASK)) begin
                                    n_pre_rem  = '0;
                                    n_interval = sel_interval(i_in_beat.write_data[1:0]);
                                    n_counter  = r_modulo;
                                end
                                n_control = i_in_beat.write_data;
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (w_sub.ge) begin
                    n_acc     = w_sub.diff;
                    n_divider = r_divider + 8'd1;
                end else begin
                    n_div_rem = r_acc[DIV_REM_W-1:0];
                    n_acc     = ACC_W'(r_pre_rem) + ACC_W'(r_cycles);
                end
            end
            ST_PRE: begin
                if (w_sub.ge) begin
                    n_acc = w_sub.diff;
                    if (r_counter == 8'hff) begin
                        n_counter       = r_modulo;
                        n_res.timer_irq = 1'b1;
                    end else begin
                        n_counter = r_counter + 8'd1;
                    end
                end else begin
                    n_pre_rem = r_acc[PRE_REM_W-1:0];
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_beat  = r_res;
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_divider   <= '0;
            r_div_rem   <= '0;
            r_counter   <= '0;
            r_modulo    <= '0;
            r_control   <= '0;
            r_pre_rem   <= '0;
            r_interval  <= INTERVAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_divider   <= n_divider;
            r_div_rem   <= n_div_rem;
            r_counter   <= n_counter;
            r_modulo    <= n_modulo;
            r_control   <= n_control;
            r_pre_rem   <= n_pre_rem;
            r_interval  <= n_interval;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_cycles   <= n_cycles;
        r_res      <= n_res;
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== design/hct_sub_unit.sv =====
// ----------------------------------------------------------------------------
// Shared compare and subtract unit
// Compares the accumulator with an interval and forms their difference.
// ----------------------------------------------------------------------------
module hct_sub_unit
    import hct_pkg::*;
(
    input  logic [ACC_W-1:0] i_minuend,
    input  logic [ACC_W-1:0] i_subtrahend,
    output t_sub_result      o_result
);

    logic [ACC_W:0] w_diff;

    assign w_diff        = {1'b0, i_minuend} - {1'b0, i_subtrahend};
    assign o_result.ge   = ~w_diff[ACC_W];
    assign o_result.diff = w_diff[ACC_W-1:0];

endmodule

// ===== tb/handheld_console_timer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handheld console timer testbench
// Drives bus reads, bus writes and cycle ticks into the timer through its
// valid/ready input channel. A scoreboard tracks the divider, counter, modulo
// and control registers with both prescalers and compares every result beat
// with its prediction. A directed sequence is followed by four random phases,
// three with random stalls on both channels and one without stalls, with one
// long receiver hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module handheld_console_timer_test;
    import hct_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int PHASE_COUNT    = 4;
    localparam int PHASE_ITEMS    = 320;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    class timer_scoreboard;
        t_out_beat   result_q[$];
        int unsigned fail_count;
        logic [7:0]  div_reg;
        logic [7:0]  tima;
        logic [7:0]  tma;
        logic [7:0]  tac;
        int unsigned div_acc;
        int unsigned pre_acc;
        int unsigned pre_period;

        function new();
            fail_count = 0;
            div_reg    = '0;
            tima       = '0;
            tma        = '0;
            tac        = '0;
            div_acc    = 0;
            pre_acc    = 0;
            pre_period = 1024;
        endfunction

        function int unsigned period_of(input logic [1:0] sel);
            case (sel)
                2'd1: return 16;
                2'd2: return 64;
                2'd3: return 256;
                default: return 1024;
            endcase
        endfunction

        function t_out_beat predict(input t_in_beat b);
            t_out_beat   r;
            int unsigned sum;
            int unsigned steps;
            r = '0;
            if (b.func == FUNC_TICK) begin
                sum     = div_acc + b.cycle_count;
                div_reg = div_reg + 8'(sum / DIV_INTERVAL);
                div_acc = sum % DIV_INTERVAL;
                if ((tac & CTL_ENABLE) != 0) begin
                    sum     = pre_acc + b.cycle_count;
                    steps   = sum / pre_period;
                    pre_acc = sum % pre_period;
                    for (int i = 0; i < steps; i++) begin
                        tima = tima + 8'd1;
                        if (tima == 8'd0) begin
                            tima        = tma;
                            r.timer_irq = 1'b1;
                        end
                    end
                end
            end else if (b.func == FUNC_READ || b.func == FUNC_WRITE) begin
                if (b.bus_address < ADDR_DIV || b.bus_address > ADDR_CTL) begin
                    r.address_error = 1'b1;
                end else if (b.func == FUNC_READ) begin
                    case (b.bus_address)
                        ADDR_DIV: r.read_data = div_reg;
                        ADDR_CNT: r.read_data = tima;
                        ADDR_MOD: r.read_data = tma;
                        default:  r.read_data = tac;
                    endcase
                end else begin
                    case (b.bus_address)
                        ADDR_DIV: begin
                            div_reg = '0;
                            div_acc = 0;
                        end
                        ADDR_CNT: tima = b.write_data;
                        ADDR_MOD: tma = b.write_data;
                        default: begin
                            if ((tac & CTL_SEL_MASK) != (b.write_data & CTL_SEL_MASK)) begin
                                pre_acc    = 0;
                                pre_period = period_of(b.write_data[1:0]);
                                tima       = tma;
                            end
                            tac = b.write_data;
                        end
                    endcase
                end
            end
            return r;
        endfunction

        function void note_input(input t_in_beat b);
            result_q.push_back(predict(b));
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(input t_out_beat got);
            t_out_beat want;
            if (result_q.size() == 0) begin
                $error("result beat %0h arrived with no prediction pending", got);
                fail_count++;
                return;
            end
            want = result_q.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("timer_irq", want.timer_irq, got.timer_irq);
            compare_field("address_error", want.address_error, got.address_error);
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    bit          idle_on = 1'b1;
    bit          rx_hold = 1'b0;
    int unsigned quiet_cycles = 0;

    timer_scoreboard sb = new();

    handheld_console_timer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                sb.check_result(out_beat);
            end
            if (in_valid && in_ready) begin
                sb.note_input(in_beat);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("handheld_console_timer_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if (rx_hold) begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_beat(input t_in_beat b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    task automatic send_op(input logic [1:0] func, input logic [15:0] addr,
                           input logic [7:0] data, input logic [7:0] cycles);
        t_in_beat b;
        b.func        = func;
        b.bus_address = addr;
        b.write_data  = data;
        b.cycle_count = cycles;
        send_beat(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic t_in_beat random_beat();
        t_in_beat    b;
        int unsigned pick;
        b.func        = FUNC_TICK;
        b.bus_address = 16'($urandom);
        b.write_data  = 8'($urandom);
        b.cycle_count = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if (pick < 9) begin
                b.cycle_count = 8'hff;
            end else if (pick < 13) begin
                b.cycle_count = 8'h00;
            end
        end else if (pick < 65) begin
            b.func        = FUNC_READ;
            b.bus_address = ADDR_DIV + 16'($urandom_range(0, 3));
        end else if (pick < 87) begin
            b.func        = FUNC_WRITE;
            b.bus_address = ADDR_DIV + 16'($urandom_range(0, 3));
            if (b.bus_address == ADDR_CTL && $urandom_range(0, 4) != 0) begin
                b.write_data[2] = 1'b1;
            end
            if (b.bus_address == ADDR_MOD && $urandom_range(0, 1) != 0) begin
                b.write_data[7:4] = 4'hf;
            end
        end else if (pick < 95) begin
            b.func = ($urandom_range(0, 1) != 0) ? FUNC_READ : FUNC_WRITE;
            if (b.bus_address >= ADDR_DIV && b.bus_address <= ADDR_CTL) begin
                b.bus_address = ~b.bus_address;
            end
        end else begin
            b.func = 2'($urandom);
        end
        return b;
    endfunction

    initial begin : stimulus
        int unsigned sent;
        t_in_beat    b;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_op(FUNC_READ, ADDR_DIV, 8'h00, 8'h00);
        send_op(FUNC_READ, ADDR_CNT, 8'h00, 8'h00);
        send_op(FUNC_READ, ADDR_MOD, 8'h00, 8'h00);
        send_op(FUNC_READ, ADDR_CTL, 8'h00, 8'h00);
        send_op(FUNC_READ, 16'h0000, 8'h00, 8'h00);
        send_op(FUNC_WRITE, 16'hffff, 8'hff, 8'hff);
        send_op(FUNC_READ, ADDR_DIV - 16'd1, 8'h00, 8'h00);
        send_op(FUNC_WRITE, ADDR_CTL + 16'd1, 8'h07, 8'h00);
        send_op(FUNC_TICK, 16'h0000, 8'h00, 8'h00);
        send_op(FUNC_TICK, 16'h0000, 8'h00, 8'hff);
        send_op(FUNC_TICK, 16'h0000, 8'h00, 8'h01);
        send_op(FUNC_WRITE, ADDR_MOD, 8'hfe, 8'h00);
        send_op(FUNC_WRITE, ADDR_CNT, 8'hff, 8'h00);
        send_op(FUNC_WRITE, ADDR_CTL, 8'h05, 8'h00);
        send_op(FUNC_TICK, 16'h0000, 8'h00, 8'hff);
        send_op(FUNC_READ, ADDR_CNT, 8'h00, 8'h00);
        send_op(FUNC_WRITE, ADDR_CTL, 8'h05, 8'h00);
        send_op(FUNC_WRITE, ADDR_CTL, 8'hff, 8'h00);
        send_op(FUNC_TICK, 16'h0000, 8'h00, 8'hff);
        send_op(FUNC_WRITE, ADDR_CTL, 8'h06, 8'h00);
        send_op(FUNC_WRITE, ADDR_DIV, 8'ha5, 8'h00);
        send_op(FUNC_READ, ADDR_DIV, 8'h00, 8'h00);
        send_op(FUNC_WRITE, ADDR_CTL, 8'h00, 8'h00);
        send_op(FUNC_TICK, 16'h0000, 8'h00, 8'd200);
        send_op(FUNC_UNUSED, 16'hffff, 8'hff, 8'hff);
        send_op(FUNC_READ, ADDR_CTL, 8'h00, 8'h00);
        drain();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            idle_on = (phase != 1);
            if (phase == 2) begin
                rx_hold = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                b = random_beat();
                send_beat(b);
                if (b.func != FUNC_UNUSED) begin
                    sent++;
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("handheld_console_timer_test: PASS");
        end else begin
            $display("handheld_console_timer_test: FAIL");
        end
        $finish;
    end

endmodule
